@@ design/gcbd_pkg.sv @@
// Shared types, constants and the rounded Q30 multiply for the bearing/distance pipeline.
`default_nettype none
package gcbd_pkg;

  localparam int QW = 34;
  localparam int AW = 36;
  localparam int ZW = 34;
  localparam int SW = 63;
  localparam int ROOT_STEPS = 31;

  typedef logic signed [QW-1:0] q_t;
  typedef logic signed [AW-1:0] vec_t;
  typedef logic signed [ZW-1:0] zang_t;
  typedef logic [SW-1:0]        root_t;

  localparam q_t CORDIC_GAIN = 34'sd652032874;

  localparam logic [31:0] ATAN_TABLE [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

  // 1e-7 degree to binary angle: 2^32 / 3.6e9 = 2^22 / 3515625
  localparam logic [32:0] RECIP_E7   = 33'd5124095576;
  localparam logic [21:0] DIV_E7     = 22'd3515625;
  localparam logic [21:0] HALF_E7    = 22'd1757812;

  localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
  localparam logic [31:0] HALF_TURN    = 32'h8000_0000;
  localparam logic [31:0] TWO_PI_Q29   = 32'd3373259426;
  localparam logic [24:0] BEARING_WRAP = 25'd23592960;
  localparam logic [11:0] ZONE_RECIP   = 12'd3641;
  localparam logic [30:0] Q30_ONE      = 31'h4000_0000;
  localparam logic [25:0] RADIUS_RESET = 26'd6371000;

  function automatic q_t mulq(input q_t a, input q_t b);
    logic [QW-1:0]   ma;
    logic [QW-1:0]   mb;
    logic [2*QW-1:0] p;
    logic [2*QW-1:0] r;
    q_t              m;
    ma = a[QW-1] ? QW'(-a) : QW'(a);
    mb = b[QW-1] ? QW'(-b) : QW'(b);
    p  = ma * mb;
    r  = (p + (2*QW)'(64'd536870912)) >> 30;
    m  = q_t'(r[QW-1:0]);
    return (a[QW-1] ^ b[QW-1]) ? -m : m;
  endfunction

endpackage
`default_nettype wire

@@ design/great_circle_bearing_distance.sv @@
// Top level: great-circle initial bearing, heading zone and haversine distance.
// Throughput: one request per cycle while the output is not stalled; the stages include the sine/cosine
// CORDIC rows, the two atan2 rows and the 31-step square root rows.
// The whole pipeline advances together and holds while a result waits at the output.
// Reset clears the valid pipeline and loads earth_radius with 6371000; no clearing pass.
`default_nettype none
module great_circle_bearing_distance #(
  parameter int CORDIC_ITERATIONS = 24
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output      logic               in_ready,
  input  wire logic signed [30:0] from_lat,
  input  wire logic signed [31:0] from_lon,
  input  wire logic signed [30:0] to_lat,
  input  wire logic signed [31:0] to_lon,
  output      logic               out_valid,
  input  wire logic               out_ready,
  output      logic        [24:0] bearing,
  output      logic        [4:0]  zone,
  output      logic        [27:0] distance,
  input  wire logic               cfg_valid,
  output      logic               cfg_ready,
  input  wire logic        [25:0] cfg_data
);

  localparam int N   = CORDIC_ITERATIONS;
  localparam int RS  = gcbd_pkg::ROOT_STEPS;
  localparam int LAT = 3 + (N + 2) + 3 + RS + (N + 2) + 2;

  logic           en;
  logic [LAT-1:0] vld;
  logic [25:0]    earth_radius;

  logic [31:0] lat1_a, lon1_a, lat2_a, lon2_a;
  logic [31:0] dlat, dlon;

  gcbd_pkg::q_t s1, c1, s2, c2, sdl, cdl, sh1, sh2;
  gcbd_pkg::q_t by1, t1, t2, h1, h2, h3, cdl1;
  gcbd_pkg::q_t by2, t1b, t3, h1b, h4;
  gcbd_pkg::q_t by3, bx3, asum;
  logic [30:0]  a3;

  logic [31:0] ang_b;
  logic [40:0] bprod;
  logic [24:0] brg_c, brg1, brg2, brg_m1;
  logic [20:0] zprod;
  logic [4:0]  zone_c, zone2;
  logic [24:0] brg_d  [RS];
  logic [4:0]  zone_d [RS];

  gcbd_pkg::root_t sv [RS+1];
  gcbd_pkg::root_t sr [RS+1];
  gcbd_pkg::root_t cv [RS+1];
  gcbd_pkg::root_t cr [RS+1];
  logic [30:0]     sa, ca;

  logic [31:0] ang_d;
  logic [64:0] rprod;
  logic [32:0] rad1;
  logic [58:0] dprod;
  logic [27:0] gc_dist;

  assign en        = !out_valid || out_ready;
  assign in_ready  = en;
  assign out_valid = vld[LAT-1];
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld          <= '0;
      earth_radius <= gcbd_pkg::RADIUS_RESET;
    end else begin
      if (en) vld <= {vld[LAT-2:0], in_valid};
      if (cfg_valid) earth_radius <= cfg_data;
    end
  end

  gcbd_to_bangle u_lat1 (.clk(clk), .en(en), .coord({from_lat[30], from_lat}), .ang(lat1_a));
  gcbd_to_bangle u_lon1 (.clk(clk), .en(en), .coord(from_lon), .ang(lon1_a));
  gcbd_to_bangle u_lat2 (.clk(clk), .en(en), .coord({to_lat[30], to_lat}), .ang(lat2_a));
  gcbd_to_bangle u_lon2 (.clk(clk), .en(en), .coord(to_lon), .ang(lon2_a));

  assign dlon = lon2_a - lon1_a;
  assign dlat = lat2_a - lat1_a;

  gcbd_sincos #(.N(N)) u_sc_lat1 (.clk(clk), .en(en), .ang(lat1_a),
                                  .sin_out(s1), .cos_out(c1));
  gcbd_sincos #(.N(N)) u_sc_lat2 (.clk(clk), .en(en), .ang(lat2_a),
                                  .sin_out(s2), .cos_out(c2));
  gcbd_sincos #(.N(N)) u_sc_dlon (.clk(clk), .en(en), .ang(dlon),
                                  .sin_out(sdl), .cos_out(cdl));
  gcbd_sincos #(.N(N)) u_sc_hlat (.clk(clk), .en(en), .ang({1'b0, dlat[31:1]}),
                                  .sin_out(sh1), .cos_out());
  gcbd_sincos #(.N(N)) u_sc_hlon (.clk(clk), .en(en), .ang({1'b0, dlon[31:1]}),
                                  .sin_out(sh2), .cos_out());

  // haversine term clamped to [0, 1]
  assign asum = h1b + h4;

  always_ff @(posedge clk) begin
    if (en) begin
      by1  <= gcbd_pkg::mulq(sdl, c2);
      t1   <= gcbd_pkg::mulq(c1, s2);
      t2   <= gcbd_pkg::mulq(s1, c2);
      h1   <= gcbd_pkg::mulq(sh1, sh1);
      h2   <= gcbd_pkg::mulq(c1, c2);
      h3   <= gcbd_pkg::mulq(sh2, sh2);
      cdl1 <= cdl;
      by2  <= by1;
      t1b  <= t1;
      t3   <= gcbd_pkg::mulq(t2, cdl1);
      h1b  <= h1;
      h4   <= gcbd_pkg::mulq(h2, h3);
      by3  <= by2;
      bx3  <= t1b - t3;
      if (asum[gcbd_pkg::QW-1]) a3 <= '0;
      else if (asum > $signed({3'b000, gcbd_pkg::Q30_ONE})) a3 <= gcbd_pkg::Q30_ONE;
      else a3 <= asum[30:0];
    end
  end

  // bearing path
  gcbd_atan2 #(.N(N)) u_at_brg (
    .clk (clk),
    .en  (en),
    .y_in(gcbd_pkg::vec_t'(by3)),
    .x_in(gcbd_pkg::vec_t'(bx3)),
    .ang (ang_b)
  );

  assign bprod  = {9'd0, ang_b} * 41'd360 + 41'd32768;
  assign brg_c  = bprod[40:16];
  assign brg_m1 = brg1 - 25'd1;
  assign zprod  = brg_m1[24:16] * gcbd_pkg::ZONE_RECIP;
  assign zone_c = (brg1 == '0) ? '0 : zprod[20:16] + 5'd1;

  always_ff @(posedge clk) begin
    if (en) begin
      brg1      <= (brg_c >= gcbd_pkg::BEARING_WRAP) ? '0 : brg_c;
      brg2      <= brg1;
      zone2     <= zone_c;
      brg_d[0]  <= brg2;
      zone_d[0] <= zone2;
      for (int i = 1; i < RS; i++) begin
        brg_d[i]  <= brg_d[i-1];
        zone_d[i] <= zone_d[i-1];
      end
    end
  end

  // distance path: two square root rows in parallel
  assign sv[0] = gcbd_pkg::root_t'({a3, 30'd0});
  assign sr[0] = '0;
  assign cv[0] = gcbd_pkg::root_t'({gcbd_pkg::Q30_ONE - a3, 30'd0});
  assign cr[0] = '0;

  for (genvar k = 0; k < RS; k++) begin : g_root
    gcbd_root_cell #(.K(RS - 1 - k)) u_sa (
      .clk(clk), .en(en), .v_in(sv[k]), .r_in(sr[k]), .v_out(sv[k+1]), .r_out(sr[k+1])
    );
    gcbd_root_cell #(.K(RS - 1 - k)) u_ca (
      .clk(clk), .en(en), .v_in(cv[k]), .r_in(cr[k]), .v_out(cv[k+1]), .r_out(cr[k+1])
    );
  end

  assign sa = sr[RS][30:0];
  assign ca = cr[RS][30:0];

  gcbd_atan2 #(.N(N)) u_at_dist (
    .clk (clk),
    .en  (en),
    .y_in(gcbd_pkg::vec_t'({5'd0, sa})),
    .x_in(gcbd_pkg::vec_t'({5'd0, ca})),
    .ang (ang_d)
  );

  assign rprod = {ang_d, 1'b0} * gcbd_pkg::TWO_PI_Q29 + 65'h0_8000_0000;
  assign dprod = earth_radius * rad1 + 59'h1000_0000;

  always_ff @(posedge clk) begin
    if (en) begin
      rad1    <= rprod[64:32];
      gc_dist <= dprod[56:29];
    end
  end

  assign bearing  = brg_d[RS-1];
  assign zone     = zone_d[RS-1];
  assign distance = gc_dist;

  a_zone_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((zone == '0) == (bearing == '0)))
    else $error("zone zero does not match bearing zero");

  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (zone <= 5'd20 && bearing < gcbd_pkg::BEARING_WRAP))
    else $error("bearing or zone out of range");

  a_freeze: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(vld))
    else $error("pipeline moved while output stalled");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");

endmodule
`default_nettype wire

@@ design/gcbd_cordic_cell.sv @@
// One CORDIC micro-rotation stage, rotation or vectoring mode.
`default_nettype none
module gcbd_cordic_cell #(
  parameter int W      = 34,
  parameter int SHIFT  = 0,
  parameter bit VECTOR = 1'b0
) (
  input  wire logic                          clk,
  input  wire logic                          en,
  input  wire logic signed [W-1:0]           x_in,
  input  wire logic signed [W-1:0]           y_in,
  input  wire gcbd_pkg::zang_t               z_in,
  output      logic signed [W-1:0]           x_out,
  output      logic signed [W-1:0]           y_out,
  output      gcbd_pkg::zang_t               z_out
);

  localparam gcbd_pkg::zang_t STEP =
    $signed({{(gcbd_pkg::ZW-32){1'b0}}, gcbd_pkg::ATAN_TABLE[SHIFT]});

  logic signed [W-1:0] dx;
  logic signed [W-1:0] dy;
  logic                up;

  assign dx = y_in >>> SHIFT;
  assign dy = x_in >>> SHIFT;
  assign up = VECTOR ? (!y_in[W-1] && (y_in != '0)) : z_in[gcbd_pkg::ZW-1];

  always_ff @(posedge clk) begin
    if (en) begin
      if (up) begin
        x_out <= x_in + dx;
        y_out <= y_in - dy;
        z_out <= z_in + STEP;
      end else begin
        x_out <= x_in - dx;
        y_out <= y_in + dy;
        z_out <= z_in - STEP;
      end
    end
  end

endmodule
`default_nettype wire

@@ design/gcbd_root_cell.sv @@
// One step of the digit-by-digit integer square root.
`default_nettype none
module gcbd_root_cell #(
  parameter int K = 0
) (
  input  wire logic            clk,
  input  wire logic            en,
  input  wire gcbd_pkg::root_t v_in,
  input  wire gcbd_pkg::root_t r_in,
  output      gcbd_pkg::root_t v_out,
  output      gcbd_pkg::root_t r_out
);

  localparam gcbd_pkg::root_t BIT = gcbd_pkg::root_t'(1) << (2 * K);

  gcbd_pkg::root_t trial;

  assign trial = r_in + BIT;

  always_ff @(posedge clk) begin
    if (en) begin
      if (v_in >= trial) begin
        v_out <= v_in - trial;
        r_out <= (r_in >> 1) + BIT;
      end else begin
        v_out <= v_in;
        r_out <= r_in >> 1;
      end
    end
  end

endmodule
`default_nettype wire

@@ design/gcbd_to_bangle.sv @@
// Three-stage conversion of a 1e-7 degree coordinate to a 32-bit binary angle.
`default_nettype none
module gcbd_to_bangle (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic signed [31:0] coord,
  output      logic        [31:0] ang
);

  localparam logic [23:0] D1 = 24'(gcbd_pkg::DIV_E7);
  localparam logic [23:0] D2 = D1 << 1;

  logic [31:0] mag_c;
  logic [64:0] prod;
  logic        neg1;
  logic [31:0] mag1;
  logic [31:0] q0;
  logic [53:0] num;
  logic [53:0] back;
  logic [53:0] rem_c;
  logic        neg2;
  logic [31:0] q0b;
  logic [23:0] rem;
  logic [31:0] q;

  assign mag_c = coord[31] ? 32'(-coord) : 32'(coord);
  assign prod  = mag_c * gcbd_pkg::RECIP_E7;

  assign num   = {mag1, 22'd0} + 54'(gcbd_pkg::HALF_E7);
  assign back  = q0 * gcbd_pkg::DIV_E7;
  assign rem_c = num - back;

  // quotient estimate is low by at most two
  always_comb begin
    if (rem >= D2) q = q0b + 32'd2;
    else if (rem >= D1) q = q0b + 32'd1;
    else q = q0b;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg1 <= coord[31];
      mag1 <= mag_c;
      q0   <= prod[63:32];
      neg2 <= neg1;
      q0b  <= q0;
      rem  <= rem_c[23:0];
      ang  <= neg2 ? 32'(-q) : q;
    end
  end

endmodule
`default_nettype wire

@@ design/gcbd_sincos.sv @@
// Rotation-mode CORDIC row: sine and cosine of a binary angle, Q30.
`default_nettype none
module gcbd_sincos #(
  parameter int N = 24
) (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [31:0] ang,
  output      gcbd_pkg::q_t sin_out,
  output      gcbd_pkg::q_t cos_out
);

  logic            flip;
  logic [31:0]     ang_f;
  logic [31:0]     ang_q;
  gcbd_pkg::zang_t z_pre;
  logic [N:0]      flip_sr;
  gcbd_pkg::q_t    xs [N+1];
  gcbd_pkg::q_t    ys [N+1];
  gcbd_pkg::zang_t zs [N+1];

  assign ang_q = ang + gcbd_pkg::QUARTER_TURN;
  assign flip  = ang_q[31];
  assign ang_f = flip ? (ang ^ gcbd_pkg::HALF_TURN) : ang;

  assign xs[0] = gcbd_pkg::CORDIC_GAIN;
  assign ys[0] = '0;
  assign zs[0] = z_pre;

  for (genvar k = 0; k < N; k++) begin : g_cell
    gcbd_cordic_cell #(.W(gcbd_pkg::QW), .SHIFT(k), .VECTOR(1'b0)) u_cell (
      .clk  (clk),
      .en   (en),
      .x_in (xs[k]),
      .y_in (ys[k]),
      .z_in (zs[k]),
      .x_out(xs[k+1]),
      .y_out(ys[k+1]),
      .z_out(zs[k+1])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      z_pre   <= $signed({{(gcbd_pkg::ZW-32){ang_f[31]}}, ang_f});
      flip_sr <= {flip_sr[N-1:0], flip};
      sin_out <= flip_sr[N] ? -ys[N] : ys[N];
      cos_out <= flip_sr[N] ? -xs[N] : xs[N];
    end
  end

endmodule
`default_nettype wire

@@ design/gcbd_atan2.sv @@
// Vectoring-mode CORDIC row: atan2(y, x) as a 32-bit binary angle.
`default_nettype none
module gcbd_atan2 #(
  parameter int N = 24
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire gcbd_pkg::vec_t y_in,
  input  wire gcbd_pkg::vec_t x_in,
  output      logic [31:0]   ang
);

  logic            zero;
  logic            neg;
  gcbd_pkg::vec_t  x_p;
  gcbd_pkg::vec_t  y_p;
  logic [N:0]      zero_sr;
  logic [N:0]      neg_sr;
  gcbd_pkg::vec_t  xs [N+1];
  gcbd_pkg::vec_t  ys [N+1];
  gcbd_pkg::zang_t zs [N+1];
  logic [31:0]     base;

  assign zero  = (x_in == '0) && (y_in == '0);
  assign neg   = x_in[gcbd_pkg::AW-1];
  assign xs[0] = x_p;
  assign ys[0] = y_p;
  assign zs[0] = '0;
  assign base  = neg_sr[N] ? gcbd_pkg::HALF_TURN : '0;

  for (genvar k = 0; k < N; k++) begin : g_cell
    gcbd_cordic_cell #(.W(gcbd_pkg::AW), .SHIFT(k), .VECTOR(1'b1)) u_cell (
      .clk  (clk),
      .en   (en),
      .x_in (xs[k]),
      .y_in (ys[k]),
      .z_in (zs[k]),
      .x_out(xs[k+1]),
      .y_out(ys[k+1]),
      .z_out(zs[k+1])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_p     <= neg ? -x_in : x_in;
      y_p     <= neg ? -y_in : y_in;
      zero_sr <= {zero_sr[N-1:0], zero};
      neg_sr  <= {neg_sr[N-1:0], neg};
      ang     <= zero_sr[N] ? '0 : base + zs[N][31:0];
    end
  end

endmodule
`default_nettype wire
